### rtl/cqkd_pkg.sv
// shared types, constants and helpers for the circular queue with key search
`default_nettype none

package cqkd_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int KEY_W   = 16;
    localparam int COUNT_W = 16;
    localparam int PRICE_W = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEC  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL         = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY        = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [STAT_W-1:0] ST_OUT_OF_STOCK = 3'd4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [PRICE_W-1:0] price;
    } rec_t;

    // write request to the record store
    typedef struct packed {
        logic rec_en;   // write the whole record
        logic cnt_en;   // write the count only
        idx_t addr;
        rec_t rec;
    } wr_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [PRICE_W-1:0] price;
    } res_t;

    function automatic idx_t next_slot(input idx_t i);
        next_slot = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/cqkd_store.sv
// record store: key, count and price arrays with one write and one registered read port
`default_nettype none

module cqkd_store
    import cqkd_pkg::*;
(
    input  wire logic aclk,
    input  wire wr_t  wr,
    input  wire idx_t rd_addr,
    output rec_t      rd_rec
);

    logic [KEY_W-1:0]   key_mem   [QUEUE_DEPTH];
    logic [COUNT_W-1:0] count_mem [QUEUE_DEPTH];
    logic [PRICE_W-1:0] price_mem [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.rec_en) begin
            key_mem[wr.addr]   <= wr.rec.key;
            price_mem[wr.addr] <= wr.rec.price;
        end
        if (wr.rec_en || wr.cnt_en) begin
            count_mem[wr.addr] <= wr.rec.count;
        end
    end

    always_ff @(posedge aclk) begin
        rd_rec.key   <= key_mem[rd_addr];
        rd_rec.count <= count_mem[rd_addr];
        rd_rec.price <= price_mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/cqkd_ctrl.sv
// sequencer: queue pointers, key search walk, shared compare/decrement unit, output register
`default_nettype none

module cqkd_ctrl
    import cqkd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [KIND_W-1:0] in_kind,
    input  wire rec_t              in_rec,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output res_t                   m_res,
    output wr_t                    wr,
    output idx_t                   rd_addr,
    input  wire rec_t              rd_rec
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_SEARCH,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    idx_t               head_reg, head_next;
    idx_t               tail_reg, tail_next;
    cnt_t               held_reg, held_next;
    idx_t               ptr_reg, ptr_next;
    cnt_t               rem_reg, rem_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    res_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    res_t               m_res_reg, m_res_next;

    logic q_empty;
    logic q_full;
    logic key_hit;

    assign q_empty = (held_reg == '0);
    assign q_full  = (held_reg == CNT_W'(QUEUE_DEPTH));
    assign key_hit = (rd_rec.key == key_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        held_next    = held_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_res_next   = m_res_reg;
        wr           = '0;
        rd_addr      = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next = in_rec.key;
                    res_next = '0;
                    unique case (in_kind)
                        KIND_PUSH: begin
                            state_next = S_EMIT;
                            if (q_full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                wr.rec_en       = 1'b1;
                                wr.addr         = tail_reg;
                                wr.rec          = in_rec;
                                tail_next       = next_slot(tail_reg);
                                held_next       = held_reg + CNT_W'(1);
                                res_next.status = ST_OK;
                            end
                        end
                        KIND_POP: begin
                            if (q_empty) begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_POP_RD;
                            end
                        end
                        KIND_DEC: begin
                            if (q_empty) begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_EMIT;
                            end else begin
                                ptr_next   = head_reg;
                                rem_next   = held_reg;
                                state_next = S_SEARCH;
                            end
                        end
                        default: begin
                            res_next.status = ST_OK;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                res_next.status = ST_OK;
                res_next.key    = rd_rec.key;
                res_next.count  = rd_rec.count;
                res_next.price  = rd_rec.price;
                held_next       = held_reg - CNT_W'(1);
                if (held_reg == CNT_W'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    head_next = next_slot(head_reg);
                end
                state_next = S_EMIT;
            end
            S_SEARCH: begin
                // read ahead of the entry under compare
                rd_addr = next_slot(ptr_reg);
                if (key_hit) begin
                    res_next.key = key_reg;
                    if (rd_rec.count != '0) begin
                        wr.cnt_en       = 1'b1;
                        wr.addr         = ptr_reg;
                        wr.rec.count    = rd_rec.count - COUNT_W'(1);
                        res_next.count  = rd_rec.count - COUNT_W'(1);
                        res_next.status = ST_OK;
                    end else begin
                        res_next.status = ST_OUT_OF_STOCK;
                    end
                    state_next = S_EMIT;
                end else if (rem_reg == CNT_W'(1)) begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_EMIT;
                end else begin
                    ptr_next = next_slot(ptr_reg);
                    rem_next = rem_reg - CNT_W'(1);
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_res_next   = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg   <= ptr_next;
        rem_reg   <= rem_next;
        key_reg   <= key_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("record count above queue depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty queue with pointers off zero");

    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == CNT_W'(QUEUE_DEPTH)) |-> (head_reg == tail_reg))
        else $error("full queue with head and tail apart");

    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg && !m_ready)) |-> $past(state_reg == S_EMIT))
        else $error("result loaded outside emit");

    a_search_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |-> (rem_reg != '0 && held_reg != '0))
        else $error("search running with nothing left to scan");
`endif

endmodule

`default_nettype wire

### rtl/circular_queue_key_decrement.sv
// top level of the circular record queue with key search and decrement
`default_nettype none

// Circular queue of up to QUEUE_DEPTH (128) records, each a 16-bit key, a 16-bit
// stock count and an opaque 32-bit price word. Every input transaction carries one
// operation and yields exactly one result transaction. Push appends at the tail
// (status full when no slot is left), pop returns the head record (status empty
// when nothing is held; popping the last record returns both pointers to slot
// zero), and decrement walks from head to tail for the first record whose key
// matches and lowers its count by one, or reports key not found or out of stock.
// s_tready is high only while the sequencer is idle. Push and unused codes
// pass from idle through the emit state to the output register, pop adds a read
// state for the registered read of the record store, and decrement adds a search
// state that compares n records: the position of the first match counted from the
// head starting at one, or every record held when the key is missing, so at most
// 128 records compared; the scan reads one store entry per cycle through the single
// read port and the one shared key compare and count decrement unit. An output
// register sits between the sequencer and m_*, so a result waiting on m_tready only
// stalls the next result, not the current search; a finished result waits in the
// emit state until the output register frees up. The record store has no reset and
// no clearing pass: only data read from slots that hold queued records is used.

module circular_queue_key_decrement
    import cqkd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transaction
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // item_key[15:0], item_count[31:16], item_price[63:32]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // result transaction
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // status[2:0], out_key[18:3], out_count[34:19],
                                        // out_price[66:35], zero pad[71:67]
);

    rec_t in_rec;
    res_t m_res;
    wr_t  wr;
    idx_t rd_addr;
    rec_t rd_rec;

    // unpack the slave payload
    assign in_rec.key   = s_tdata[15:0];
    assign in_rec.count = s_tdata[31:16];
    assign in_rec.price = s_tdata[63:32];

    // sequencer with pointers, search walk and output register
    cqkd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .in_kind (s_tuser),
        .in_rec  (in_rec),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec)
    );

    // record memory, registered read
    cqkd_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec)
    );

    // pack the master payload, lowest field first
    assign m_tdata = {5'd0, m_res.price, m_res.count, m_res.key, m_res.status};

endmodule

`default_nettype wire

### tb/tb_circular_queue_key_decrement.sv
// self-checking testbench for the circular record queue with key search and decrement
`timescale 1ns / 1ps

module tb_circular_queue_key_decrement;
    import cqkd_pkg::*;

    // the fourth operation code is unused by the block and must act as a no-op
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 6;
    localparam int LONG_HOLD     = 300;  // cycles the receiver holds off under pressure
    localparam int DRAIN_CYCLES  = 150;  // covers a full-depth key scan plus overhead
    localparam int MAX_REPORTS   = 10;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input channel, all driven to known values from time zero
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // item_key[15:0], item_count[31:16], item_price[63:32]
    logic [1:0]  s_tuser  = '0;   // kind[1:0]

    // result channel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // status[2:0], out_key[18:3], out_count[34:19],
                                  // out_price[66:35], zero pad[71:67]

    // shadow copy of the queue used to predict every result
    rec_t shadow_rec [QUEUE_DEPTH];
    idx_t shadow_head  = '0;
    idx_t shadow_tail  = '0;
    bit   shadow_empty = 1'b1;

    // results predicted at input acceptance, oldest first
    res_t pending_results [$];

    // bookkeeping
    int  mismatch_count = 0;
    int  ops_accepted   = 0;
    int  results_seen   = 0;
    int  status_seen [0:7];

    // idling controls shared between the test tasks and the two channel processes
    bit  tx_gaps   = 1'b0;
    bit  rx_stalls = 1'b0;
    int  hold_requests = 0;
    int  holds_served  = 0;
    int  rx_hold       = 0;

    circular_queue_key_decrement dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns period
    always #2 aclk = ~aclk;

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // keys mostly from a small pool so that searches hit, sometimes anything
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 70)
            return {($urandom_range(0, 1) ? 12'hFFF : 12'h000), 4'($urandom_range(0, 15))};
        else
            return KEY_W'($urandom);
    endfunction

    // small counts run out of stock quickly, wide ones exercise every bit
    function automatic logic [COUNT_W-1:0] pick_count();
        if ($urandom_range(0, 99) < 60)
            return COUNT_W'($urandom_range(0, 2));
        else
            return COUNT_W'($urandom);
    endfunction

    // applies one operation to the shadow queue and returns the result it must produce
    function automatic res_t queue_op_result(input logic [KIND_W-1:0]  kind,
                                             input logic [KEY_W-1:0]   key,
                                             input logic [COUNT_W-1:0] count,
                                             input logic [PRICE_W-1:0] price);
        res_t r;
        idx_t slot;
        idx_t span;
        int   held;
        r = '0;
        r.status = ST_OK;
        case (kind)
            KIND_PUSH: begin
                if (!shadow_empty && shadow_tail == shadow_head) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_rec[shadow_tail] = '{key: key, count: count, price: price};
                    // depth is a power of two, so the index wraps on its own
                    shadow_tail  = shadow_tail + 1'b1;
                    shadow_empty = 1'b0;
                end
            end
            KIND_POP: begin
                if (shadow_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key   = shadow_rec[shadow_head].key;
                    r.count = shadow_rec[shadow_head].count;
                    r.price = shadow_rec[shadow_head].price;
                    shadow_head = shadow_head + 1'b1;
                    // last record gone: both pointers go back to slot zero
                    if (shadow_head == shadow_tail) begin
                        shadow_empty = 1'b1;
                        shadow_head  = '0;
                        shadow_tail  = '0;
                    end
                end
            end
            KIND_DEC: begin
                if (shadow_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    span = shadow_tail - shadow_head;
                    held = (span == '0) ? QUEUE_DEPTH : int'(span);
                    slot = shadow_head;
                    r.status = ST_NOT_FOUND;
                    for (int k = 0; k < held; k++) begin
                        if (shadow_rec[slot].key == key) begin
                            // only the first matching record is looked at
                            r.key = key;
                            if (shadow_rec[slot].count != '0) begin
                                shadow_rec[slot].count = shadow_rec[slot].count - 1'b1;
                                r.count  = shadow_rec[slot].count;
                                r.status = ST_OK;
                            end else begin
                                r.status = ST_OUT_OF_STOCK;
                            end
                            break;
                        end
                        slot = slot + 1'b1;
                    end
                end
            end
            default: begin
                // unused code: no operation, ok status, zero fields
            end
        endcase
        status_seen[r.status]++;
        return r;
    endfunction

    // offers one transaction on the input channel and records its prediction at acceptance
    task automatic send_op(input logic [KIND_W-1:0]  kind,
                           input logic [KEY_W-1:0]   key,
                           input logic [COUNT_W-1:0] count,
                           input logic [PRICE_W-1:0] price);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {price, count, key};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(queue_op_result(kind, key, count, price));
        ops_accepted++;
    endtask

    // receiver: random short and long stalls, plus the long hold the pressure test asks for
    always @(negedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rx_hold = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
            rx_hold = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compares every result transaction with the oldest prediction
    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got.status = m_tdata[2:0];
            got.key    = m_tdata[18:3];
            got.count  = m_tdata[34:19];
            got.price  = m_tdata[66:35];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: status %0d key %h count %h price %h",
                             $realtime, got.status, got.key, got.count, got.price);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.key !== want.key ||
                    got.count !== want.count || got.price !== want.price ||
                    m_tdata[71:67] !== '0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected status %0d key %h count %h price %h, got status %0d key %h count %h price %h pad %b",
                                 $realtime, want.status, want.key, want.count, want.price,
                                 got.status, got.key, got.count, got.price, m_tdata[71:67]);
                end
            end
        end
    end

    // pop, decrement and the unused code on an empty queue
    task automatic test_empty_queue();
        send_op(KIND_POP,    16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_DEC,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // field extremes, every outcome of a key search, and popping the last record
    task automatic test_record_cases();
        send_op(KIND_PUSH, 16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_PUSH, 16'h0007, 16'h0000, 32'h0000_0001);
        send_op(KIND_PUSH, 16'h0007, 16'h0003, 32'h0000_0002);
        send_op(KIND_DEC,  16'h0000, 16'h0000, 32'h0000_0000);  // out of stock
        send_op(KIND_DEC,  16'hFFFF, 16'h0000, 32'h0000_0000);  // count at its maximum
        send_op(KIND_DEC,  16'h0007, 16'h0000, 32'h0000_0000);  // first match is empty
        send_op(KIND_DEC,  16'h1234, 16'h0000, 32'h0000_0000);  // key not found
        send_op(KIND_PUSH, 16'h0005, 16'h0001, 32'hA5A5_A5A5);
        send_op(KIND_DEC,  16'h0005, 16'h0000, 32'h0000_0000);  // count goes to zero
        send_op(KIND_DEC,  16'h0005, 16'h0000, 32'h0000_0000);  // then out of stock
        send_op(KIND_POP,  16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_POP,  16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_POP,  16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_DEC,  16'h0007, 16'h0000, 32'h0000_0000);  // now the stocked duplicate
        send_op(KIND_POP,  16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_POP,  16'h0000, 16'h0000, 32'h0000_0000);  // last record leaves
        send_op(KIND_POP,  16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_PUSH, 16'h0001, 16'h0001, 32'h5A5A_5A5A);  // pointers restarted at zero
        send_op(KIND_POP,  16'h0000, 16'h0000, 32'h0000_0000);
    endtask

    // fill to capacity, push when full, search the whole depth, wrap the tail and drain
    task automatic test_fill_and_wrap();
        logic [KEY_W-1:0] last_key;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            // low bits carry the slot so every key is unique
            last_key = {9'($urandom), 7'(i)};
            send_op(KIND_PUSH, last_key, pick_count(), $urandom);
        end
        send_op(KIND_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_PUSH, 16'h0000, 16'h0000, 32'h0000_0000);
        send_op(KIND_DEC, last_key, 16'h0000, 32'h0000_0000);         // hit in the last slot
        send_op(KIND_DEC, ~last_key, 16'h0000, 32'h0000_0000);        // full scan, no hit
        for (int i = 0; i < 50; i++)
            send_op(KIND_POP, 16'h0000, 16'h0000, 32'h0000_0000);
        for (int i = 0; i < 50; i++) begin
            last_key = {9'h1FF, 7'(i)};
            send_op(KIND_PUSH, last_key, pick_count(), $urandom);
        end
        send_op(KIND_DEC, last_key, 16'h0000, 32'h0000_0000);         // scan across the wrap
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_op(KIND_POP, 16'h0000, 16'h0000, 32'h0000_0000);
    endtask

    // the receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_requests++;
        for (int i = 0; i < 30; i++)
            send_op((i % 3 == 2) ? KIND_DEC : KIND_PUSH, pick_key(), pick_count(), $urandom);
    endtask

    // long random mix, alternating phases that grow and shrink the queue
    task automatic test_random_mix();
        int push_pct;
        int pop_pct;
        int r;
        logic [KIND_W-1:0] kind;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0, 2: begin push_pct = 60; pop_pct = 10; end
                1, 3: begin push_pct = 10; pop_pct = 60; end
                default: begin push_pct = 35; pop_pct = 30; end
            endcase
            // idling on in some phases, a clean stretch in the others
            tx_gaps   = (phase != 1);
            rx_stalls = (phase != 2);
            for (int i = 0; i < ((phase == 4) ? 100 : 250); i++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    kind = KIND_UNUSED;
                else if (r < 3 + push_pct)
                    kind = KIND_PUSH;
                else if (r < 3 + push_pct + pop_pct)
                    kind = KIND_POP;
                else
                    kind = KIND_DEC;
                send_op(kind, pick_key(), pick_count(), $urandom);
            end
        end
    endtask

    initial begin
        foreach (status_seen[i])
            status_seen[i] = 0;

        // reset once, synchronous and active low
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_record_cases();
        test_fill_and_wrap();
        test_output_backpressure();
        test_random_mix();

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // every prediction has to be met, then watch for stray results
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d operations, %0d results: ok %0d, full %0d, empty %0d, not found %0d, out of stock %0d",
                 ops_accepted, results_seen, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND], status_seen[ST_OUT_OF_STOCK]);
        $display("covered a full queue, tail wrap, whole-depth searches and a %0d-cycle output hold; %0d mismatches",
                 LONG_HOLD, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard, well beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("timeout with %0d results still expected", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
